>>> hw/rtl/kmd_pkg.sv
package kmd_pkg;

    localparam int ROWS_DEF      = 8;
    localparam int COLS_DEF      = 16;
    localparam int TICK_BITS_DEF = 32;

    // Fixed field widths of the ports
    localparam int IN_COLS = 16;
    localparam int ROW_W   = 3;
    localparam int COL_W   = 4;
    localparam int NOW_W   = 32;
    localparam int CFG_W   = 32;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 32'd10;

    // One row's worth of lane findings, handed to the event merger
    typedef struct packed {
        logic [IN_COLS-1:0] mask;
        logic [IN_COLS-1:0] press;
        logic [ROW_W-1:0]   row;
    } evt_load_t;

endpackage

>>> hw/rtl/key_matrix_debouncer.sv
// Channel  Direction  Handshake           Word
// in       sink       in_valid/in_ready   row_index, column_levels, now_tick
// out      source     out_valid/out_ready event_row, event_column, is_press, last_event
// cfg      sink       cfg_we              cfg_wdata (debounce_ticks)
//
// A row word is read from the tick RAM in its accept cycle, all key lanes evaluate
// it in the next cycle and write the row back once the event merger takes the row;
// one lane per column runs in parallel. Events leave one per cycle in column order
// while out_ready is high, so the event merger sets the sustained rate.
// A new word is taken while earlier events are still being delivered.
// Reset clears keys to released, ticks to zero (per-row valid bits), debounce_ticks to 10.
module key_matrix_debouncer #(
    parameter int ROWS      = kmd_pkg::ROWS_DEF,
    parameter int COLS      = kmd_pkg::COLS_DEF,
    parameter int TICK_BITS = kmd_pkg::TICK_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [kmd_pkg::ROW_W-1:0]     row_index,
    input  logic [kmd_pkg::IN_COLS-1:0]   column_levels,
    input  logic [kmd_pkg::NOW_W-1:0]     now_tick,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [kmd_pkg::ROW_W-1:0]     event_row,
    output logic [kmd_pkg::COL_W-1:0]     event_column,
    output logic                          is_press,
    output logic                          last_event,
    input  logic                          cfg_we,
    input  logic [kmd_pkg::CFG_W-1:0]     cfg_wdata
);

    localparam int NLANE     = (COLS < kmd_pkg::IN_COLS) ? COLS : kmd_pkg::IN_COLS;
    localparam int ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int RAM_W     = NLANE * TICK_BITS;

    logic [kmd_pkg::CFG_W-1:0] debounce_ticks_reg;

    logic [NLANE-1:0] raw_prev_reg [ROWS];
    logic [NLANE-1:0] stable_reg [ROWS];
    logic [ROWS-1:0]  row_valid_reg;

    // stage 1: accepted word, waiting on RAM read data
    logic                        s1_valid_reg, s1_valid_next;
    logic [kmd_pkg::ROW_W-1:0]   s1_row_reg;
    logic [NLANE-1:0]            s1_levels_reg;
    logic [TICK_BITS-1:0]        s1_now_reg;
    logic                        byp_reg;
    logic [RAM_W-1:0]            byp_data_reg;

    logic                        accept;
    logic                        s1_fire;
    logic                        s1_in_range;
    logic [ROW_IDX_W-1:0]        s1_sel;
    logic                        load_ready;
    logic [RAM_W-1:0]            ram_rdata;
    logic [RAM_W-1:0]            tick_row;
    logic [RAM_W-1:0]            tick_row_new;
    logic [NLANE-1:0]            last_row;
    logic [NLANE-1:0]            stable_row;
    logic [NLANE-1:0]            fire_row;
    logic                        ram_we;
    kmd_pkg::evt_load_t          load;

    assign accept      = in_valid && in_ready;
    assign s1_fire     = s1_valid_reg && load_ready;
    assign in_ready    = !s1_valid_reg || load_ready;
    assign s1_in_range = 32'(s1_row_reg) < ROWS;
    assign s1_sel      = ROW_IDX_W'(s1_row_reg);
    assign ram_we      = s1_fire && s1_in_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg <= kmd_pkg::DEBOUNCE_RESET;
        end
        else if (cfg_we)
        begin
            debounce_ticks_reg <= cfg_wdata;
        end
    end

    kmd_ram #(
        .WIDTH (RAM_W),
        .DEPTH (ROWS),
        .ADDR_W(ROW_IDX_W)
    ) u_tick_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(s1_sel),
        .wdata(tick_row_new),
        .re   (accept),
        .raddr(ROW_IDX_W'(row_index)),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        tick_row   = '0;
        last_row   = '0;
        stable_row = '0;
        if (s1_in_range)
        begin
            last_row   = raw_prev_reg[s1_sel];
            stable_row = stable_reg[s1_sel];
            if (byp_reg)
            begin
                tick_row = byp_data_reg;
            end
            else if (row_valid_reg[s1_sel])
            begin
                tick_row = ram_rdata;
            end
        end
    end

    for (genvar c = 0; c < NLANE; c++)
    begin : g_lane
        kmd_lane #(
            .TICK_BITS(TICK_BITS)
        ) u_lane (
            .raw           (s1_levels_reg[c]),
            .last          (last_row[c]),
            .stable        (stable_row[c]),
            .tick_old      (tick_row[c*TICK_BITS +: TICK_BITS]),
            .now           (s1_now_reg),
            .debounce_ticks(debounce_ticks_reg),
            .tick_new      (tick_row_new[c*TICK_BITS +: TICK_BITS]),
            .fire          (fire_row[c])
        );
    end

    always_comb
    begin
        load       = '0;
        load.row   = s1_row_reg;
        load.press = kmd_pkg::IN_COLS'(s1_levels_reg);
        if (s1_in_range)
        begin
            load.mask = kmd_pkg::IN_COLS'(fire_row);
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            byp_reg       <= 1'b0;
            row_valid_reg <= '0;
            for (int r = 0; r < ROWS; r++)
            begin
                raw_prev_reg[r] <= '0;
                stable_reg[r]   <= '0;
            end
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                // RAM read is read-first: forward the row written this cycle
                byp_reg <= ram_we && (row_index == s1_row_reg);
            end
            if (ram_we)
            begin
                row_valid_reg[s1_sel] <= 1'b1;
                raw_prev_reg[s1_sel]  <= s1_levels_reg;
                stable_reg[s1_sel]    <= stable_row ^ fire_row;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_row_reg    <= row_index;
            s1_levels_reg <= NLANE'(column_levels);
            s1_now_reg    <= TICK_BITS'(now_tick);
            byp_data_reg  <= tick_row_new;
        end
    end

    kmd_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_valid  (s1_valid_reg),
        .load        (load),
        .load_ready  (load_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_row   (event_row),
        .event_column(event_column),
        .is_press    (is_press),
        .last_event  (last_event)
    );

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("input stalled with empty stage");

    a_write_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (s1_valid_reg && load_ready))
        else $error("tick RAM written without a row in flight");

    a_bypass_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && byp_reg) |-> s1_in_range)
        else $error("bypass set for an unmapped row");

endmodule

>>> hw/rtl/kmd_ram.sv
module kmd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        // read-first: a same-address write is not seen here
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/kmd_lane.sv
module kmd_lane #(
    parameter int TICK_BITS = kmd_pkg::TICK_BITS_DEF
) (
    input  logic                     raw,
    input  logic                     last,
    input  logic                     stable,
    input  logic [TICK_BITS-1:0]     tick_old,
    input  logic [TICK_BITS-1:0]     now,
    input  logic [kmd_pkg::CFG_W-1:0] debounce_ticks,
    output logic [TICK_BITS-1:0]     tick_new,
    output logic                     fire
);

    localparam int CMP_W = (TICK_BITS > kmd_pkg::CFG_W) ? TICK_BITS : kmd_pkg::CFG_W;

    logic                 changed;
    logic [TICK_BITS-1:0] elapsed;
    logic                 expired;

    assign changed  = raw ^ last;
    assign elapsed  = now - tick_old;
    assign expired  = CMP_W'(elapsed) > CMP_W'(debounce_ticks);
    assign tick_new = changed ? now : tick_old;
    // a fresh change has zero elapsed time and never fires
    assign fire     = !changed && expired && (raw != stable);

endmodule

>>> hw/rtl/kmd_merge.sv
module kmd_merge (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load_valid,
    input  kmd_pkg::evt_load_t          load,
    output logic                        load_ready,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [kmd_pkg::ROW_W-1:0]   event_row,
    output logic [kmd_pkg::COL_W-1:0]   event_column,
    output logic                        is_press,
    output logic                        last_event
);

    localparam int N = kmd_pkg::IN_COLS;

    logic [N-1:0]              mask_reg, mask_next;
    logic [N-1:0]              press_reg;
    logic [kmd_pkg::ROW_W-1:0] row_reg;

    logic                      out_valid_reg, out_valid_next;
    logic [kmd_pkg::ROW_W-1:0] ev_row_reg;
    logic [kmd_pkg::COL_W-1:0] ev_col_reg;
    logic                      ev_press_reg;
    logic                      ev_last_reg;

    logic [N-1:0]              pick;
    logic [N-1:0]              mask_left;
    logic [kmd_pkg::COL_W-1:0] pick_col;
    logic                      advance;

    // lowest pending column first
    assign pick      = mask_reg & (~mask_reg + N'(1));
    assign mask_left = mask_reg & ~pick;
    assign advance   = (|mask_reg) && (!out_valid_reg || out_ready);

    always_comb
    begin
        pick_col = '0;
        for (int i = 0; i < N; i++)
        begin
            if (pick[i])
            begin
                pick_col = kmd_pkg::COL_W'(i);
            end
        end
    end

    assign load_ready = advance ? (mask_left == '0) : (mask_reg == '0);

    always_comb
    begin
        mask_next = advance ? mask_left : mask_reg;
        if (load_valid && load_ready)
        begin
            mask_next = load.mask;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_valid && load_ready)
        begin
            press_reg <= load.press;
            row_reg   <= load.row;
        end
        if (advance)
        begin
            ev_row_reg   <= row_reg;
            ev_col_reg   <= pick_col;
            ev_press_reg <= |(press_reg & pick);
            ev_last_reg  <= (mask_left == '0);
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_row    = ev_row_reg;
    assign event_column = ev_col_reg;
    assign is_press     = ev_press_reg;
    assign last_event   = ev_last_reg;

endmodule
